FILE: hw/rtl/rtd_pkg.sv
// Shared types and constants for the RTD code to temperature converter.
`default_nettype none
package rtd_pkg;

  // configuration register indexes
  localparam logic [1:0] CFG_REFERENCE = 2'd0;
  localparam logic [1:0] CFG_NOMINAL   = 2'd1;
  localparam logic [1:0] CFG_LINEAR    = 2'd2;
  localparam logic [1:0] CFG_SQUARE    = 2'd3;

  localparam int CFG_W    = 33;
  localparam int TEMP_W   = 15;
  localparam int BMAG_W   = 33;
  localparam int DIFF_W   = 31;
  localparam int UQ_W     = 49;   // quotient bits of (d-n)*2^32/d
  localparam int UREM_W   = 63;   // DIFF_W + 32
  localparam int RAD_W    = 85;
  localparam int ROOT_W   = 42;

  localparam logic [TEMP_W-1:0] TEMP_MAX = 15'h3FFF;
  localparam logic [TEMP_W-1:0] TEMP_MIN = 15'h4000;

  // per-item flags that ride along the cell chains
  typedef struct packed {
    logic uneg;    // resistance ratio above one
    logic fault;   // converter fault flag
    logic bad;     // no quadratic to solve
    logic negrad;  // radicand below zero
    logic nneg;    // root numerator negative
    logic big;     // quotient beyond 15 bits
  } rtd_tag_t;

endpackage
`default_nettype wire

FILE: hw/rtl/rtd_div_cell.sv
// One restoring division step: tries one quotient bit and passes the remainder on.
`default_nettype none
module rtd_div_cell #(
  parameter int REM_W = 63,
  parameter int DIV_W = 31,
  parameter int Q_W   = 49,
  parameter int SHIFT = 0
) (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    en,
  input  wire                    valid_i,
  input  wire  [REM_W-1:0]       rem_i,
  input  wire  [Q_W-1:0]         quo_i,
  input  wire  [DIV_W-1:0]       divisor,
  input  rtd_pkg::rtd_tag_t      tag_i,
  output logic                   valid_o,
  output logic [REM_W-1:0]       rem_o,
  output logic [Q_W-1:0]         quo_o,
  output rtd_pkg::rtd_tag_t      tag_o
);
  import rtd_pkg::*;

  localparam int CMP_W = REM_W + DIV_W;

  logic [CMP_W-1:0] dsh;
  logic [CMP_W-1:0] remx;
  logic             ge;
  logic [REM_W-1:0] rem_nxt;
  logic [Q_W-1:0]   quo_nxt;

  always_comb begin
    dsh     = CMP_W'(divisor) << SHIFT;
    remx    = CMP_W'(rem_i);
    ge      = (remx >= dsh);
    rem_nxt = ge ? REM_W'(remx - dsh) : rem_i;
    quo_nxt = quo_i | (Q_W'(ge) << SHIFT);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_o <= 1'b0;
    end else if (en) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_o <= rem_nxt;
      quo_o <= quo_nxt;
      tag_o <= tag_i;
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/rtd_sqrt_cell.sv
// One digit-by-digit square root step: decides one root bit.
`default_nettype none
module rtd_sqrt_cell #(
  parameter int W     = 85,
  parameter int RES_W = 42,
  parameter int BIT   = 0
) (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    en,
  input  wire                    valid_i,
  input  wire  [W-1:0]           rem_i,
  input  wire  [RES_W-1:0]       res_i,
  input  rtd_pkg::rtd_tag_t      tag_i,
  output logic                   valid_o,
  output logic [W-1:0]           rem_o,
  output logic [RES_W-1:0]       res_o,
  output rtd_pkg::rtd_tag_t      tag_o
);
  import rtd_pkg::*;

  logic [W-1:0]     trial;
  logic             ge;
  logic [W-1:0]     rem_nxt;
  logic [RES_W-1:0] res_nxt;

  // (res + 2^b)^2 - res^2 = res*2^(b+1) + 2^(2b); res holds only bits above b
  always_comb begin
    trial   = (W'(res_i) << (BIT + 1)) | (W'(1) << (2 * BIT));
    ge      = (rem_i >= trial);
    rem_nxt = ge ? (rem_i - trial) : rem_i;
    res_nxt = res_i | (RES_W'(ge) << BIT);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_o <= 1'b0;
    end else if (en) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_o <= rem_nxt;
      res_o <= res_nxt;
      tag_o <= tag_i;
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/rtd_code_to_temperature.sv
// Top level: RTD data word to Callendar-Van Dusen temperature, fully pipelined.
//
// Input channel in_valid/in_stall carries one 16-bit converter word per beat:
// bits 15..1 the ratio code, bit 0 the fault flag. Output channel
// out_valid/out_stall returns one beat per word: temperature in units of
// 2^-TEMP_FRACTION_BITS degree, a fault copy and an out-of-range flag.
// Throughput is one word per cycle while the pipeline is not stalled. From
// acceptance to out_valid a word passes through the cell chains: 49 cells for
// the resistance ratio quotient, 42 for the square root and 15 for the final
// divide, plus six stages of scaling, multiplying and combining.
// When the receiver stalls, the output register holds its beat and the
// chain keeps moving as long as its last stage is empty, so bubbles squeeze
// out; in_stall rises only when a finished beat waits behind the held one.
// Reset (rst_n low, synchronous) empties the pipeline and restores the
// register defaults: 400 ohm reference, 100 ohm nominal, A and B of the
// standard platinum curve. The user must write registers through cfg_write
// only while the block is idle; the block itself does not enforce this.
`default_nettype none
module rtd_code_to_temperature #(
  parameter int TEMP_FRACTION_BITS = 4
) (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire                         in_valid,
  output logic                        in_stall,
  input  wire  [15:0]                 in_rtd_word,
  output logic                        out_valid,
  input  wire                         out_stall,
  output logic signed [14:0]          out_temperature,
  output logic                        out_fault,
  output logic                        out_out_of_range,
  input  wire                         cfg_write,
  input  wire  [1:0]                  cfg_index,
  input  wire  [rtd_pkg::CFG_W-1:0]   cfg_data
);
  import rtd_pkg::*;

  // dividend width of the final divide: root bits, scale shift, rounding carry
  localparam int M_W = ROOT_W + 7 + TEMP_FRACTION_BITS + 1;

  // ---------------- configuration registers ----------------
  logic [15:0] cfg_ref_r, cfg_nom_r;
  logic [31:0] cfg_lin_r;
  logic [32:0] cfg_sq_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_ref_r <= 16'd400;
      cfg_nom_r <= 16'd100;
      cfg_lin_r <= 32'd16786021;
      cfg_sq_r  <= 33'h1_F64F_A809;   // -162551799
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_REFERENCE: cfg_ref_r <= cfg_data[15:0];
        CFG_NOMINAL:   cfg_nom_r <= cfg_data[15:0];
        CFG_LINEAR:    cfg_lin_r <= cfg_data[31:0];
        CFG_SQUARE:    cfg_sq_r  <= cfg_data[32:0];
        default:       ;
      endcase
    end
  end

  // constants derived from the registers, stable while items are in flight
  logic              bneg;
  logic [BMAG_W-1:0] bmag;
  logic [DIFF_W-1:0] dval;

  assign bneg = cfg_sq_r[32];
  assign bmag = bneg ? (BMAG_W'(0) - cfg_sq_r) : cfg_sq_r;
  assign dval = {cfg_nom_r, 15'd0};

  // ---------------- flow control ----------------
  logic en;
  logic last_valid;
  logic out_load;

  assign en       = !(out_valid && out_stall && last_valid);
  assign in_stall = !en;
  assign out_load = !out_valid || !out_stall;

  // ---------------- stage A: ratio difference ----------------
  logic [DIFF_W-1:0] a_n, a_diff_nxt;
  rtd_tag_t          a_tag_nxt;
  logic              a_valid_r;
  logic [DIFF_W-1:0] a_diff_r;
  rtd_tag_t          a_tag_r;

  always_comb begin
    a_n        = DIFF_W'(in_rtd_word[15:1]) * DIFF_W'(cfg_ref_r);
    a_tag_nxt  = '0;
    a_tag_nxt.fault = in_rtd_word[0];
    a_tag_nxt.bad   = (cfg_nom_r == 16'd0) || (bmag == '0);
    a_tag_nxt.uneg  = (a_n > dval);
    a_diff_nxt = a_tag_nxt.uneg ? (a_n - dval) : (dval - a_n);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (en) begin
      a_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_diff_r <= a_diff_nxt;
      a_tag_r  <= a_tag_nxt;
    end
  end

  // ---------------- ratio quotient chain: |d-n|*2^32/d ----------------
  logic              u_valid [0:UQ_W];
  logic [UREM_W-1:0] u_rem   [0:UQ_W];
  logic [UQ_W-1:0]   u_quo   [0:UQ_W];
  rtd_tag_t          u_tag   [0:UQ_W];

  assign u_valid[0] = a_valid_r;
  assign u_rem[0]   = {a_diff_r, 32'd0};
  assign u_quo[0]   = '0;
  assign u_tag[0]   = a_tag_r;

  for (genvar g = 0; g < UQ_W; g++) begin : g_udiv
    rtd_div_cell #(
      .REM_W(UREM_W), .DIV_W(DIFF_W), .Q_W(UQ_W), .SHIFT(UQ_W - 1 - g)
    ) u_cell (
      .clk(clk), .rst_n(rst_n), .en(en),
      .valid_i(u_valid[g]), .rem_i(u_rem[g]), .quo_i(u_quo[g]),
      .divisor(dval), .tag_i(u_tag[g]),
      .valid_o(u_valid[g+1]), .rem_o(u_rem[g+1]), .quo_o(u_quo[g+1]),
      .tag_o(u_tag[g+1])
    );
  end

  // ---------------- stage B: partial products ----------------
  logic        b_valid_r;
  logic [57:0] b_plo_r;
  logic [56:0] b_phi_r;
  logic [63:0] b_a2_r;
  rtd_tag_t    b_tag_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else if (en) begin
      b_valid_r <= u_valid[UQ_W];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_plo_r <= 58'(bmag) * 58'(u_quo[UQ_W][24:0]);
      b_phi_r <= 57'(bmag) * 57'(u_quo[UQ_W][48:25]);
      b_a2_r  <= 64'(cfg_lin_r) * 64'(cfg_lin_r);
      b_tag_r <= u_tag[UQ_W];
    end
  end

  // ---------------- stage C: 4*B*u and A^2 in Q.80 ----------------
  logic             c_valid_r;
  logic [RAD_W-1:0] c_prod_r, c_rad_r;
  rtd_tag_t         c_tag_r;
  logic [RAD_W-1:0] c_prod_nxt;

  assign c_prod_nxt = (RAD_W'(b_plo_r) + (RAD_W'(b_phi_r) << 25)) << 2;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_valid_r <= 1'b0;
    end else if (en) begin
      c_valid_r <= b_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_prod_r <= c_prod_nxt;
      c_rad_r  <= RAD_W'(b_a2_r) << 16;
      c_tag_r  <= b_tag_r;
    end
  end

  // ---------------- stage D: radicand ----------------
  logic             d_valid_r;
  logic [RAD_W-1:0] d_rad_r, d_rad_nxt;
  rtd_tag_t         d_tag_r, d_tag_nxt;

  always_comb begin
    d_tag_nxt = c_tag_r;
    if (bneg == c_tag_r.uneg) begin
      d_tag_nxt.negrad = (c_prod_r > c_rad_r);
      d_rad_nxt        = c_rad_r - c_prod_r;
    end else begin
      d_rad_nxt        = c_rad_r + c_prod_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_valid_r <= 1'b0;
    end else if (en) begin
      d_valid_r <= c_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_rad_r <= d_rad_nxt;
      d_tag_r <= d_tag_nxt;
    end
  end

  // ---------------- square root chain ----------------
  logic              r_valid [0:ROOT_W];
  logic [RAD_W-1:0]  r_rem   [0:ROOT_W];
  logic [ROOT_W-1:0] r_res   [0:ROOT_W];
  rtd_tag_t          r_tag   [0:ROOT_W];

  assign r_valid[0] = d_valid_r;
  assign r_rem[0]   = d_rad_r;
  assign r_res[0]   = '0;
  assign r_tag[0]   = d_tag_r;

  for (genvar g = 0; g < ROOT_W; g++) begin : g_sqrt
    rtd_sqrt_cell #(
      .W(RAD_W), .RES_W(ROOT_W), .BIT(ROOT_W - 1 - g)
    ) r_cell (
      .clk(clk), .rst_n(rst_n), .en(en),
      .valid_i(r_valid[g]), .rem_i(r_rem[g]), .res_i(r_res[g]), .tag_i(r_tag[g]),
      .valid_o(r_valid[g+1]), .rem_o(r_rem[g+1]), .res_o(r_res[g+1]),
      .tag_o(r_tag[g+1])
    );
  end

  // ---------------- stage E: numerator and rounding offset ----------------
  logic              e_valid_r;
  logic [M_W-1:0]    e_num_r, e_num_nxt;
  rtd_tag_t          e_tag_r, e_tag_nxt;
  logic [ROOT_W-1:0] e_amid, e_m;

  always_comb begin
    e_amid    = ROOT_W'({cfg_lin_r, 8'd0});
    e_tag_nxt = r_tag[ROOT_W];
    e_tag_nxt.nneg = (r_res[ROOT_W] < e_amid);
    e_m       = e_tag_nxt.nneg ? (e_amid - r_res[ROOT_W]) : (r_res[ROOT_W] - e_amid);
    e_num_nxt = (M_W'(e_m) << (7 + TEMP_FRACTION_BITS)) + M_W'(bmag >> 1);
    e_tag_nxt.big = (e_num_nxt >= (M_W'(bmag) << TEMP_W));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_valid_r <= 1'b0;
    end else if (en) begin
      e_valid_r <= r_valid[ROOT_W];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e_num_r <= e_num_nxt;
      e_tag_r <= e_tag_nxt;
    end
  end

  // ---------------- final divide chain: 15 quotient bits ----------------
  logic              q_valid [0:TEMP_W];
  logic [M_W-1:0]    q_rem   [0:TEMP_W];
  logic [TEMP_W-1:0] q_quo   [0:TEMP_W];
  rtd_tag_t          q_tag   [0:TEMP_W];

  assign q_valid[0] = e_valid_r;
  assign q_rem[0]   = e_num_r;
  assign q_quo[0]   = '0;
  assign q_tag[0]   = e_tag_r;

  for (genvar g = 0; g < TEMP_W; g++) begin : g_qdiv
    rtd_div_cell #(
      .REM_W(M_W), .DIV_W(BMAG_W), .Q_W(TEMP_W), .SHIFT(TEMP_W - 1 - g)
    ) q_cell (
      .clk(clk), .rst_n(rst_n), .en(en),
      .valid_i(q_valid[g]), .rem_i(q_rem[g]), .quo_i(q_quo[g]),
      .divisor(bmag), .tag_i(q_tag[g]),
      .valid_o(q_valid[g+1]), .rem_o(q_rem[g+1]), .quo_o(q_quo[g+1]),
      .tag_o(q_tag[g+1])
    );
  end

  assign last_valid = q_valid[TEMP_W];

  // ---------------- output register: sign, saturation, flags ----------------
  logic [TEMP_W-1:0] f_q, f_temp;
  rtd_tag_t          f_tag;
  logic              f_tneg, f_oor;

  always_comb begin
    f_q    = q_quo[TEMP_W];
    f_tag  = q_tag[TEMP_W];
    f_tneg = (f_tag.nneg != bneg) && (f_tag.big || (f_q != '0));
    f_temp = '0;
    f_oor  = 1'b0;
    priority if (f_tag.fault) begin
      f_temp = '0;
    end else if (f_tag.bad) begin
      f_oor  = 1'b1;
    end else if (f_tag.negrad) begin
      f_oor  = 1'b1;
      f_temp = f_tag.uneg ? TEMP_MAX : TEMP_MIN;
    end else if (!f_tneg) begin
      if (f_tag.big || f_q[TEMP_W-1]) begin
        f_oor  = 1'b1;
        f_temp = TEMP_MAX;
      end else begin
        f_temp = f_q;
      end
    end else begin
      if (f_tag.big || (f_q > TEMP_MIN)) begin
        f_oor  = 1'b1;
        f_temp = TEMP_MIN;
      end else begin
        f_temp = TEMP_W'(0) - f_q;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= last_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_temperature  <= f_temp;
      out_fault        <= f_tag.fault;
      out_out_of_range <= f_oor;
    end
  end

`ifndef SYNTH
  // input only backs up behind a held output beat
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("in_stall without a held output beat");

  // a faulted word reports zero and no range flag
  a_fault_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_fault) |-> (out_temperature == '0 && !out_out_of_range))
    else $error("fault beat with nonzero temperature or range flag");

  // a finished beat is never overwritten while the receiver holds off
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall && last_valid) |=> $stable(out_temperature))
    else $error("held output beat changed");

  // reset empties the output
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");
`endif

endmodule
`default_nettype wire

FILE: test/rtd_code_to_temperature_tb.sv
// Testbench for the RTD code to temperature converter: predictor, scoreboard and stimulus.
module rtd_code_to_temperature_tb;
  import rtd_pkg::*;

  localparam int FRAC_BITS   = 4;
  localparam int DRAIN_WAIT  = 150;     // past the pipeline latency
  localparam int CYCLE_LIMIT = 600000;

  typedef struct packed {
    logic [TEMP_W-1:0] temperature;
    logic              fault;
    logic              out_of_range;
  } temp_beat_t;

  // Predicts each result word and keeps the ones still owed by the block.
  class temp_scoreboard;
    logic [15:0] ref_ohms;
    logic [15:0] nom_ohms;
    logic [31:0] lin_coef;
    logic [32:0] sq_coef;
    temp_beat_t  owed[$];
    int          mismatches;

    function new();
      ref_ohms = 16'd400;
      nom_ohms = 16'd100;
      lin_coef = 32'd16786021;
      sq_coef  = 33'h1_0000_0000 + 33'h1_0000_0000 - 33'd162551799;
      mismatches = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [CFG_W-1:0] val);
      case (idx)
        CFG_REFERENCE: ref_ohms = val[15:0];
        CFG_NOMINAL:   nom_ohms = val[15:0];
        CFG_LINEAR:    lin_coef = val[31:0];
        CFG_SQUARE:    sq_coef  = val[32:0];
        default: ;
      endcase
    endfunction

    function logic [127:0] isqrt(logic [127:0] v);
      logic [127:0] r;
      logic [127:0] c;
      r = '0;
      for (int i = 41; i >= 0; i--) begin
        c = r | (128'd1 << i);
        if (c * c <= v) r = c;
      end
      return r;
    endfunction

    function temp_beat_t convert(logic [15:0] word);
      temp_beat_t   t;
      logic         bneg, uneg, nneg, tneg;
      logic [127:0] bmag, d, n, umag, rad, prod, s, amid, m, q;
      t = '0;
      if (word[0]) begin
        t.fault = 1'b1;
        return t;
      end
      bneg = sq_coef[32];
      bmag = bneg ? (128'h2_0000_0000 - {95'd0, sq_coef}) : {95'd0, sq_coef};
      if (nom_ohms == 0 || bmag == 0) begin
        t.out_of_range = 1'b1;
        return t;
      end
      d = {112'd0, nom_ohms} << 15;
      n = {113'd0, word[15:1]} * {112'd0, ref_ohms};
      uneg = n > d;
      umag = uneg ? (((n - d) << 32) / d) : (((d - n) << 32) / d);
      rad  = ({96'd0, lin_coef} * {96'd0, lin_coef}) << 16;
      prod = (bmag * umag) << 2;
      if (umag != 0) begin
        if (bneg == uneg) begin
          if (prod > rad) begin
            // radicand below zero: rail toward the side of the ratio
            t.temperature  = uneg ? TEMP_MAX : TEMP_MIN;
            t.out_of_range = 1'b1;
            return t;
          end
          rad = rad - prod;
        end else begin
          rad = rad + prod;
        end
      end
      s    = isqrt(rad);
      amid = {96'd0, lin_coef} << 8;
      nneg = s < amid;
      m    = nneg ? (amid - s) : (s - amid);
      m    = m << (7 + FRAC_BITS);
      q    = (m + (bmag >> 1)) / bmag;
      tneg = (nneg != bneg) && q != 0;
      if (!tneg) begin
        if (q > 16383) begin
          q = 16383;
          t.out_of_range = 1'b1;
        end
        t.temperature = q[TEMP_W-1:0];
      end else begin
        if (q > 16384) begin
          q = 16384;
          t.out_of_range = 1'b1;
        end
        t.temperature = 15'(-q);
      end
      return t;
    endfunction

    function void note_word(logic [15:0] word);
      owed.push_back(convert(word));
    endfunction

    function void check_beat(temp_beat_t got);
      temp_beat_t want;
      if (owed.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %h", got);
        return;
      end
      want = owed.pop_front();
      if (got.temperature !== want.temperature || got.fault !== want.fault ||
          got.out_of_range !== want.out_of_range) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: temp %h/%h fault %b/%b oor %b/%b (exp/act)",
                   want.temperature, got.temperature, want.fault, got.fault,
                   want.out_of_range, got.out_of_range);
      end
    endfunction
  endclass

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic [15:0]              in_rtd_word = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic signed [TEMP_W-1:0] out_temperature;
  logic                     out_fault;
  logic                     out_out_of_range;
  logic                     cfg_write = 1'b0;
  logic [1:0]               cfg_index = CFG_REFERENCE;
  logic [CFG_W-1:0]         cfg_data = '0;

  temp_scoreboard sb = new();
  bit  quiet = 1'b0;    // no idling on either side while set
  int  cycles = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  rtd_code_to_temperature #(.TEMP_FRACTION_BITS(FRAC_BITS)) i_dut (
    .clk, .rst_n, .in_valid, .in_stall, .in_rtd_word, .out_valid, .out_stall,
    .out_temperature, .out_fault, .out_out_of_range, .cfg_write, .cfg_index, .cfg_data
  );

  // Monitor: both channels sampled at the rising edge.
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) sb.note_word(in_rtd_word);
    if (rst_n && out_valid && !out_stall)
      sb.check_beat('{out_temperature, out_fault, out_out_of_range});
  end

  // Receiver backpressure, moved at the falling edge.
  always @(negedge clk) begin
    out_stall <= !quiet && ($urandom_range(99) < 17);
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("rtd_code_to_temperature_tb: FAIL");
      $finish;
    end
  end

  // One input beat; stays in the task until the block takes it.
  task automatic send_word(logic [15:0] word);
    if (!quiet && $urandom_range(99) < 17) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_valid    = 1'b1;
    in_rtd_word = word;
    forever begin
      @(posedge clk);
      if (!in_stall) break;
    end
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic drain();
    wait (sb.owed.size() == 0);
    repeat (DRAIN_WAIT) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [CFG_W-1:0] val);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(negedge clk);
    cfg_write = 1'b0;
    sb.set_reg(idx, val);
  endtask

  task automatic load_config(logic [15:0] r, logic [15:0] n, logic [31:0] a,
                             logic [32:0] b);
    drain();
    write_reg(CFG_REFERENCE, {17'd0, r});
    write_reg(CFG_NOMINAL, {17'd0, n});
    write_reg(CFG_LINEAR, {1'b0, a});
    write_reg(CFG_SQUARE, b);
  endtask

  // Mostly codes near the zero-degree ratio so the root lands in range.
  function automatic logic [15:0] pick_word();
    logic [14:0] code;
    int          base;
    if ($urandom_range(3) == 0) return 16'($urandom);
    base = (sb.ref_ohms == 0) ? 0 : (32768 * sb.nom_ohms) / sb.ref_ohms;
    if (base > 32767) base = 32767;
    code = 15'(base + $signed($urandom_range(8000)) - 4000);
    return {code, ($urandom_range(9) == 0)};
  endfunction

  task automatic run_items(int count);
    for (int i = 0; i < count; i++) begin
      send_word(pick_word());
    end
  endtask

  initial begin
    logic [15:0] directed[$];
    directed = '{16'h0000, 16'h0001, 16'hFFFF, 16'hFFFE, 16'h4000, 16'h4002,
                 16'h3FFE, 16'h5000, 16'h3000, 16'h0002, 16'h8000, 16'hAAAA,
                 16'h5554, 16'h7FFE, 16'h4A00, 16'h2000};
    repeat (4) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // defaults straight out of reset
    foreach (directed[k]) send_word(directed[k]);
    run_items(120);

    // pause until the pipe is empty, then resume
    wait (sb.owed.size() == 0);
    quiet = 1'b1;
    run_items(200);
    quiet = 1'b0;

    // corners of every register
    load_config(16'hFFFF, 16'h0001, 32'hFFFF_FFFF, 33'h1_0000_0000);
    foreach (directed[k]) send_word(directed[k]);
    run_items(40);
    load_config(16'h0001, 16'hFFFF, 32'h0, 33'h1_FFFF_FFFF);
    foreach (directed[k]) send_word(directed[k]);
    run_items(40);
    // degenerate quadratic and a positive square term
    load_config(16'd400, 16'd0, 32'd16786021, 33'h0);
    run_items(20);
    load_config(16'd400, 16'd100, 32'd16786021, 33'd162551799);
    run_items(40);

    // near-platinum and free random settings
    for (int p = 0; p < 8; p++) begin
      if (p[0])
        load_config(16'($urandom_range(65535, 1)), 16'($urandom_range(65535, 1)),
                    $urandom, {1'b1, 32'($urandom)});
      else
        load_config(16'($urandom_range(4300, 390)), 16'($urandom_range(1000, 100)),
                    32'($urandom_range(18000000, 15000000)),
                    33'd0 - 33'($urandom_range(200000000, 120000000)));
      run_items(95);
    end

    drain();
    if (sb.mismatches == 0 && sb.owed.size() == 0)
      $display("rtd_code_to_temperature_tb: PASS");
    else
      $display("rtd_code_to_temperature_tb: FAIL");
    $finish;
  end
endmodule
